// File: src/slp_pkg.sv
// Shared types and constants for the sampler voice playback block.
`timescale 1ns / 1ps
package slp_pkg;

  localparam int ADDR_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int PITCH_W    = 24;
  localparam int LSTART_W   = 16;
  localparam int LEND_W     = 17;
  localparam int LEN_W      = 17;
  localparam int MODE_W     = 3;
  localparam int IDX_W      = 18;

  localparam logic [PITCH_W-1:0] PITCH_RST = 24'h010000;
  localparam logic [LEND_W-1:0]  LEND_RST  = 17'h10000;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PITCH  = 3'd0,
    REG_LSTART = 3'd1,
    REG_LEND   = 3'd2,
    REG_LEN    = 3'd3,
    REG_MODE   = 3'd4
  } cfg_reg_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE    = 3'd0,
    MODE_FWD     = 3'd1,
    MODE_REV     = 3'd2,
    MODE_PING    = 3'd3,
    MODE_ONESHOT = 3'd4
  } loop_mode_t;

  typedef struct packed {
    logic zero;
    logic ended;
  } tick_ctl_t;

endpackage

// File: src/slp_if.sv
// Channel interfaces: input items, result items and configuration writes.
`timescale 1ns / 1ps
interface slp_in_if #(parameter int SAMPLE_BITS = 16);
  import slp_pkg::*;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    opcode;
  logic [ADDR_W-1:0]             address;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  modport source (output valid, opcode, address, sample_in, input ready);
  modport sink   (input valid, opcode, address, sample_in, output ready);
endinterface

interface slp_out_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] audio_out;
  logic                          ended;
  modport source (output valid, audio_out, ended, input ready);
  modport sink   (input valid, audio_out, ended, output ready);
endinterface

interface slp_cfg_if;
  import slp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/slp_store.sv
// Sample memory: one write port, two registered read ports.
`timescale 1ns / 1ps
module slp_store #(
  parameter int STORE_DEPTH = 65536,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [$clog2(STORE_DEPTH)-1:0]     wr_addr,
  input  logic signed [SAMPLE_BITS-1:0]      wr_data,
  input  logic                               rd_en,
  input  logic [$clog2(STORE_DEPTH)-1:0]     rd_addr0,
  input  logic [$clog2(STORE_DEPTH)-1:0]     rd_addr1,
  output logic signed [SAMPLE_BITS-1:0]      rd_data0,
  output logic signed [SAMPLE_BITS-1:0]      rd_data1
);

  logic signed [SAMPLE_BITS-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
    end
  end

endmodule

// File: src/slp_voice.sv
// Voice control: config registers, position, loop rule, memory access issue.
`timescale 1ns / 1ps
module slp_voice #(
  parameter int STORE_DEPTH = 65536,
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  slp_in_if.sink                             in_ch,
  slp_cfg_if.sink                            cfg_ch,
  input  logic                               take,
  output logic                               s1_valid,
  output slp_pkg::tick_ctl_t                 s1_ctl,
  output logic [FRAC_BITS-1:0]               s1_frac,
  output logic                               wr_en,
  output logic [$clog2(STORE_DEPTH)-1:0]     wr_addr,
  output logic signed [SAMPLE_BITS-1:0]      wr_data,
  output logic                               rd_en,
  output logic [$clog2(STORE_DEPTH)-1:0]     rd_addr0,
  output logic [$clog2(STORE_DEPTH)-1:0]     rd_addr1
);
  import slp_pkg::*;

  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int POS_W = FRAC_BITS + IDX_W;
  localparam int WB    = POS_W + 3;
  localparam int XW    = (AW > IDX_W) ? AW : IDX_W;
  localparam int LW    = (AW > ADDR_W) ? AW : ADDR_W;
  localparam int SHL   = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SHR   = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;
  localparam logic signed [WB-1:0] POS_HI = {{(WB-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
  localparam logic signed [WB-1:0] POS_LO = ~POS_HI;

  logic [PITCH_W-1:0]      pitch_r;
  logic [LSTART_W-1:0]     lstart_r;
  logic [LEND_W-1:0]       lend_r;
  logic [LEN_W-1:0]        len_r;
  logic [MODE_W-1:0]       mode_r;

  logic signed [POS_W-1:0] pos_r, pos_nxt;
  logic                    back_r, back_nxt;
  logic                    end_r, end_nxt;

  logic                    s1_valid_r, s1_valid_nxt;
  tick_ctl_t               s1_ctl_r;
  logic [FRAC_BITS-1:0]    s1_frac_r;

  logic                    acc, tick_acc, start_acc;
  logic [IDX_W-1:0]        idx;
  logic [XW-1:0]           idx_x;
  logic [LW-1:0]           ld_x;
  logic                    pos_neg, len_zero, end_interp, end_adv, looping;
  logic signed [WB-1:0]    step_w, pos_x, p, pn, s_fx, e_fx, len_fx;
  tick_ctl_t               ctl_nxt;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !s1_valid_r || take;
  assign acc          = in_ch.valid && in_ch.ready;
  assign tick_acc     = acc && (in_ch.opcode == OP_TICK);
  assign start_acc    = acc && (in_ch.opcode == OP_START);

  // sample writes
  assign ld_x    = LW'(in_ch.address);
  assign wr_en   = acc && (in_ch.opcode == OP_LOAD);
  assign wr_addr = ld_x[AW-1:0];
  assign wr_data = in_ch.sample_in;

  // neighbor reads
  assign idx      = pos_r[POS_W-1:FRAC_BITS];
  assign idx_x    = XW'(idx);
  assign rd_en    = tick_acc;
  assign rd_addr0 = idx_x[AW-1:0];
  assign rd_addr1 = AW'(idx_x + XW'(1));

  assign pos_neg    = pos_r[POS_W-1];
  assign len_zero   = (len_r == '0);
  assign end_interp = !pos_neg && !len_zero
                      && ((IDX_W+1)'(idx) + (IDX_W+1)'(1) >= (IDX_W+1)'(len_r));

  assign step_w = $signed((WB'(pitch_r) << SHL) >> SHR);
  assign pos_x  = WB'(pos_r);
  assign s_fx   = $signed(WB'(lstart_r) << FRAC_BITS);
  assign e_fx   = $signed(WB'(lend_r) << FRAC_BITS);
  assign len_fx = $signed(WB'(len_r) << FRAC_BITS);
  assign p      = back_r ? pos_x - step_w : pos_x + step_w;
  assign looping = (mode_r == MODE_FWD) || (mode_r == MODE_REV) || (mode_r == MODE_PING);

  always_comb begin
    pn       = p;
    back_nxt = back_r;
    end_adv  = 1'b0;
    case (mode_r)
      MODE_FWD: begin
        if (p >= e_fx) pn = p + (s_fx - e_fx);
      end
      MODE_REV: begin
        if (p <= s_fx) pn = p + (e_fx - s_fx);
      end
      MODE_PING: begin
        if (!back_r && p >= e_fx) begin
          back_nxt = 1'b1;
          pn       = (e_fx <<< 1) - p;
        end else if (back_r && p <= s_fx) begin
          back_nxt = 1'b0;
          pn       = (s_fx <<< 1) - p;
        end
      end
      MODE_NONE, MODE_ONESHOT: begin
        if (p >= len_fx) end_adv = 1'b1;
      end
      default: begin
      end
    endcase
    if (pn > POS_HI) pn = POS_HI;
    if (pn < POS_LO) pn = POS_LO;
  end

  always_comb begin
    pos_nxt      = pos_r;
    end_nxt      = end_r;
    s1_valid_nxt = take ? 1'b0 : s1_valid_r;
    ctl_nxt.zero  = pos_neg || len_zero || end_interp;
    ctl_nxt.ended = (end_r || end_interp || end_adv) && !looping;
    if (tick_acc) begin
      pos_nxt      = pn[POS_W-1:0];
      end_nxt      = end_r || end_interp || end_adv;
      s1_valid_nxt = 1'b1;
    end else if (start_acc) begin
      pos_nxt = '0;
      end_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      back_r     <= 1'b0;
      end_r      <= 1'b0;
      s1_valid_r <= 1'b0;
      pitch_r    <= PITCH_RST;
      lstart_r   <= '0;
      lend_r     <= LEND_RST;
      len_r      <= '0;
      mode_r     <= MODE_NONE;
    end else begin
      pos_r      <= pos_nxt;
      end_r      <= end_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (tick_acc) begin
        back_r <= back_nxt;
      end else if (start_acc) begin
        back_r <= 1'b0;
      end
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          REG_PITCH:  pitch_r  <= cfg_ch.data[PITCH_W-1:0];
          REG_LSTART: lstart_r <= cfg_ch.data[LSTART_W-1:0];
          REG_LEND:   lend_r   <= cfg_ch.data[LEND_W-1:0];
          REG_LEN:    len_r    <= cfg_ch.data[LEN_W-1:0];
          REG_MODE:   mode_r   <= cfg_ch.data[MODE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      s1_ctl_r  <= ctl_nxt;
      s1_frac_r <= pos_r[FRAC_BITS-1:0];
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_ctl   = s1_ctl_r;
  assign s1_frac  = s1_frac_r;

endmodule

// File: src/slp_interp.sv
// Linear interpolation of the two read samples and the result register.
`timescale 1ns / 1ps
module slp_interp #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s1_valid,
  input  slp_pkg::tick_ctl_t            s1_ctl,
  input  logic [FRAC_BITS-1:0]          s1_frac,
  input  logic signed [SAMPLE_BITS-1:0] rd_data0,
  input  logic signed [SAMPLE_BITS-1:0] rd_data1,
  output logic                          take,
  slp_out_if.source                     out_ch
);
  import slp_pkg::*;

  localparam int PW = SAMPLE_BITS + FRAC_BITS + 2;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);

  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] audio_r, audio_nxt;
  logic                          ended_r;

  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [FRAC_BITS:0]     fr;
  logic signed [PW-1:0]          prod, q;
  logic signed [SAMPLE_BITS+1:0] res;

  // s1 + round((s2 - s1) * frac / one)
  assign diff = (SAMPLE_BITS+1)'(rd_data1) - (SAMPLE_BITS+1)'(rd_data0);
  assign fr   = $signed({1'b0, s1_frac});
  assign prod = PW'(diff * fr);
  assign q    = (prod + HALF) >>> FRAC_BITS;
  assign res  = (SAMPLE_BITS+2)'(rd_data0) + q[SAMPLE_BITS+1:0];
  assign audio_nxt = s1_ctl.zero ? '0 : res[SAMPLE_BITS-1:0];

  assign take = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && s1_valid) begin
      audio_r <= audio_nxt;
      ended_r <= s1_ctl.ended;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.audio_out = audio_r;
  assign out_ch.ended     = ended_r;

endmodule

// File: src/sample_loop_playback.sv
// Top level of the sampler voice: sample memory, voice control, interpolation.
//
//  channel | dir | handshake     | payload
//  in_ch   | in  | valid / ready | opcode, address, sample_in
//  out_ch  | out | valid / ready | audio_out, ended (one per tick item)
//  cfg_ch  | in  | valid / ready | index, data (ready always high)
//
//  One item per cycle while in_ch.ready is high; a tick's result passes the
//  s1 stage registers and read ports, then the result register, to out_ch.
//  Position update and loop rule are combinational ahead of pos_r; the two
//  neighbor samples come from two registered read ports of the sample memory.
//  Reset clears position, direction, end flag, pipeline valids, presets config;
//  sample memory keeps its contents and is undefined until loaded.
//  A stalled result holds the interpolation stage, then in_ch.ready drops.
`timescale 1ns / 1ps
module sample_loop_playback #(
  parameter int STORE_DEPTH = 65536,
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  slp_in_if.sink     in_ch,
  slp_out_if.source  out_ch,
  slp_cfg_if.sink    cfg_ch
);
  import slp_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);

  logic                          take;
  logic                          s1_valid;
  tick_ctl_t                     s1_ctl;
  logic [FRAC_BITS-1:0]          s1_frac;
  logic                          wr_en, rd_en;
  logic [AW-1:0]                 wr_addr, rd_addr0, rd_addr1;
  logic signed [SAMPLE_BITS-1:0] wr_data, rd_data0, rd_data1;

  slp_voice #(
    .STORE_DEPTH (STORE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_voice (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .take     (take),
    .s1_valid (s1_valid),
    .s1_ctl   (s1_ctl),
    .s1_frac  (s1_frac),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1)
  );

  slp_store #(
    .STORE_DEPTH (STORE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1)
  );

  slp_interp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_interp (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_ctl   (s1_ctl),
    .s1_frac  (s1_frac),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1),
    .take     (take),
    .out_ch   (out_ch)
  );

`ifndef SYNTHESIS
  a_tick_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && (in_ch.opcode == OP_TICK) |=> s1_valid)
    else $error("accepted tick did not reach the interpolation stage");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid && !take |-> !in_ch.ready)
    else $error("input accepted while interpolation stage is stalled");

  a_stage_to_output: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid && take |=> out_ch.valid)
    else $error("interpolation stage item lost before the result register");
`endif

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the sampler voice: directed and random items against a voice model.
`timescale 1ns / 1ps
module tb_top;
  import slp_pkg::*;

  localparam int     LIMIT        = 400000;
  localparam int     RANDOM_ITEMS = 1600;
  localparam int     SAT_TICKS    = 530;
  localparam int     FRAC         = 16;
  localparam longint BIAS         = 32768;
  localparam longint POS_MAX      = 64'sd8589934591;
  localparam longint POS_MIN      = -64'sd8589934592;
  localparam longint unsigned ONE = 64'd65536;

  localparam logic [1:0]           OP_UNUSED   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 3'd7;
  localparam logic [MODE_W-1:0]    MODE_UNUSED = 3'd7;

  typedef struct packed {
    logic [15:0] audio;
    logic        ended;
  } audio_item_t;

  class voice_checker;
    logic signed [15:0]  samples [65536];
    longint              pos;
    bit                  moving_back;
    bit                  end_flag;
    logic [PITCH_W-1:0]  pitch;
    logic [LSTART_W-1:0] lstart;
    logic [LEND_W-1:0]   lend;
    logic [LEN_W-1:0]    len;
    logic [MODE_W-1:0]   mode;
    audio_item_t         expected_audio [$];
    int                  errors;

    function new();
      pos         = 0;
      moving_back = 1'b0;
      end_flag    = 1'b0;
      pitch       = PITCH_RST;
      lstart      = '0;
      lend        = LEND_RST;
      len         = '0;
      mode        = MODE_NONE;
      errors      = 0;
    endfunction

    function int pending();
      return expected_audio.size();
    endfunction

    function void note_reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_PITCH:  pitch  = data[PITCH_W-1:0];
        REG_LSTART: lstart = data[LSTART_W-1:0];
        REG_LEND:   lend   = data[LEND_W-1:0];
        REG_LEN:    len    = data[LEN_W-1:0];
        REG_MODE:   mode   = data[MODE_W-1:0];
        default: ;
      endcase
    endfunction

    // True when the next tick blends samples lo_idx and lo_idx + 1.
    function bit tick_reads(output int lo_idx);
      longint idx;
      idx    = pos >>> FRAC;
      lo_idx = int'(idx);
      return pos >= 0 && len != 0 && idx < longint'(len) - 1;
    endfunction

    function logic [15:0] blend();
      longint          idx;
      longint unsigned frac, u1, u2, acc;
      if (pos < 0 || len == 0) return '0;
      idx  = pos >>> FRAC;
      frac = pos & 64'hFFFF;
      if (idx >= longint'(len) - 1) begin
        end_flag = 1'b1;
        return '0;
      end
      u1  = longint'(samples[16'(idx)]) + BIAS;
      u2  = longint'(samples[16'(idx + 1)]) + BIAS;
      acc = u1 * (ONE - frac) + u2 * frac + (ONE >> 1);
      return 16'((acc >> FRAC) - BIAS);
    endfunction

    function void advance();
      longint step, s, e, p;
      step = longint'(pitch);
      s    = longint'(lstart) <<< FRAC;
      e    = longint'(lend) <<< FRAC;
      p    = moving_back ? pos - step : pos + step;
      case (mode)
        MODE_FWD: begin
          if (p >= e) p = s + (p - e);
        end
        MODE_REV: begin
          if (p <= s) p = e - (s - p);
        end
        MODE_PING: begin
          if (!moving_back && p >= e) begin
            moving_back = 1'b1;
            p = e - (p - e);
          end else if (moving_back && p <= s) begin
            moving_back = 1'b0;
            p = s + (s - p);
          end
        end
        MODE_NONE, MODE_ONESHOT: begin
          if (p >= (longint'(len) <<< FRAC)) end_flag = 1'b1;
        end
        default: ;
      endcase
      pos = (p > POS_MAX) ? POS_MAX : (p < POS_MIN) ? POS_MIN : p;
    endfunction

    function void note_item(logic [1:0] op, logic [ADDR_W-1:0] addr, logic [15:0] smp);
      audio_item_t res;
      case (op)
        OP_LOAD: samples[addr] = smp;
        OP_START: begin
          pos         = 0;
          moving_back = 1'b0;
          end_flag    = 1'b0;
        end
        OP_TICK: begin
          res.audio = blend();
          advance();
          res.ended = end_flag && !(mode inside {MODE_FWD, MODE_REV, MODE_PING});
          expected_audio.insert(expected_audio.size(), res);
        end
        default: ;
      endcase
    endfunction

    function void check_audio(logic [15:0] audio, logic ended);
      audio_item_t want;
      if (expected_audio.size() == 0) begin
        $error("unexpected result item: audio_out %0d ended %0b", $signed(audio), ended);
        errors++;
        return;
      end
      want = expected_audio.pop_front();
      if (audio !== want.audio) begin
        $error("audio_out: expected %0d actual %0d", $signed(want.audio), $signed(audio));
        errors++;
      end
      if (ended !== want.ended) begin
        $error("ended: expected %0b actual %0b", want.ended, ended);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  slp_in_if  #(.SAMPLE_BITS(16)) in_ch ();
  slp_out_if #(.SAMPLE_BITS(16)) out_ch ();
  slp_cfg_if                     cfg_ch ();

  sample_loop_playback u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  voice_checker voice = new();
  bit           loaded [65536];
  int           send_gap_pct   = 0;
  int           recv_stall_pct = 0;
  int           hold_left      = 0;
  int           cycles         = 0;
  int           counted        = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Receiver: random stalls, plus long hold-offs counted here.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) voice.note_reg_write(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready)
        voice.note_item(in_ch.opcode, in_ch.address, in_ch.sample_in);
      if (out_ch.valid && out_ch.ready) voice.check_audio(out_ch.audio_out, out_ch.ended);
    end
  end

  function automatic logic [15:0] rand_sample();
    int r;
    r = $urandom_range(15);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7FFF;
    return 16'($urandom);
  endfunction

  task automatic send_item(logic [1:0] op, logic [ADDR_W-1:0] addr, logic [15:0] smp);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.opcode    = op;
    in_ch.address   = addr;
    in_ch.sample_in = smp;
    if (op == OP_LOAD) loaded[addr] = 1'b1;
    if (op != OP_UNUSED) counted++;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Loads any neighbor sample the tick would read before it was ever written.
  task automatic play_tick();
    int lo;
    if (voice.tick_reads(lo)) begin
      if (!loaded[lo]) send_item(OP_LOAD, 16'(lo), rand_sample());
      if (!loaded[lo + 1]) send_item(OP_LOAD, 16'(lo + 1), rand_sample());
    end
    send_item(OP_TICK, 16'($urandom), 16'($urandom));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic settle();
    in_ch.valid = 1'b0;
    while (voice.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic configure(int pitch, int ls, int le, int len, logic [MODE_W-1:0] mode);
    settle();
    write_reg(REG_PITCH, 24'(pitch));
    write_reg(REG_LSTART, 24'(ls));
    write_reg(REG_LEND, 24'(le));
    write_reg(REG_LEN, 24'(len));
    write_reg(REG_MODE, 24'(mode));
  endtask

  task automatic start_note();
    send_item(OP_START, 16'($urandom), 16'($urandom));
  endtask

  initial begin
    int r, n, w, phase, len, ls, le, pitch;
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] addr;
    in_ch.valid     = 1'b0;
    in_ch.opcode    = OP_LOAD;
    in_ch.address   = '0;
    in_ch.sample_in = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_PITCH;
    cfg_ch.data     = '0;
    rst_n           = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty sample, unused opcode, extreme blends, end of sample, loop modes.
    play_tick();
    send_item(OP_UNUSED, 16'hFFFF, 16'hFFFF);
    configure(24'h008000, 0, 17'h10000, 4, MODE_NONE);
    write_reg(REG_SPARE, 24'hFFFFFF);
    send_item(OP_LOAD, 16'd0, 16'h7FFF);
    send_item(OP_LOAD, 16'd1, 16'h8000);
    send_item(OP_LOAD, 16'd2, 16'h0000);
    send_item(OP_LOAD, 16'd3, 16'h0001);
    send_item(OP_LOAD, 16'hFFFF, 16'hFFFF);
    start_note();
    repeat (8) play_tick();
    start_note();
    play_tick();
    configure(24'hFFFFFF, 0, 1, 4, MODE_PING);
    start_note();
    repeat (3) play_tick();
    configure(24'h018000, 1, 3, 4, MODE_REV);
    start_note();
    repeat (4) play_tick();

    // Saturation both ways: reverse direction left over from ping-pong, then forward.
    send_gap_pct   = 12;
    recv_stall_pct = 12;
    configure(24'h010000, 0, 1, 4, MODE_PING);
    start_note();
    play_tick();
    configure(24'hFFFFFF, 0, 1, 4, MODE_UNUSED);
    repeat (SAT_TICKS) play_tick();
    configure(24'hFFFFFF, 0, 17'h10000, 4, MODE_ONESHOT);
    start_note();
    repeat (SAT_TICKS) play_tick();

    phase = 0;
    while (counted < RANDOM_ITEMS || phase < 4) begin
      case (phase % 4)
        0: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_gap_pct   = 67;
          recv_stall_pct = 0;
        end
        2: begin
          send_gap_pct   = 0;
          recv_stall_pct = 67;
        end
        default: begin
          send_gap_pct   = 12;
          recv_stall_pct = 12;
        end
      endcase

      r = $urandom_range(9);
      if (r == 0) len = 0;
      else if (r == 1) len = 1;
      else if (r == 2) len = 65536;
      else if (r == 3) len = $urandom_range(65536);
      else len = $urandom_range(64, 2);
      r = $urandom_range(9);
      if (r == 0) ls = 65535;
      else if (r == 1) ls = 0;
      else ls = $urandom_range(len > 65535 ? 65535 : len);
      r = $urandom_range(9);
      if (r == 0) le = 65536;
      else if (r == 1) le = 0;
      else le = $urandom_range(len > ls ? len : ls + 1, ls);
      case ($urandom_range(5))
        0:       pitch = 1;
        1:       pitch = 65536;
        2:       pitch = 24'hFFFFFF;
        3:       pitch = $urandom_range(24'hFFFFFF, 1);
        default: pitch = $urandom_range(24'h030000, 1);
      endcase
      r = $urandom_range(11);
      mode = (r < 10) ? 3'(r % 5) : 3'(5 + $urandom_range(2));
      configure(pitch, ls, le, len, mode);

      start_note();
      if (phase == 2) hold_left = 400;
      n = $urandom_range(140, 60);
      repeat (n) begin
        r = $urandom_range(99);
        if (r < 70) begin
          play_tick();
        end else if (r < 88) begin
          addr = ($urandom_range(9) < 7) ? 16'($urandom_range(len > 0 ? len - 1 : 0))
                                         : 16'($urandom);
          send_item(OP_LOAD, addr, rand_sample());
        end else if (r < 96) begin
          start_note();
        end else begin
          send_item(OP_UNUSED, 16'($urandom), 16'($urandom));
        end
      end
      phase++;
    end

    in_ch.valid = 1'b0;
    for (w = 0; w < 10000 && voice.pending() != 0; w++) @(negedge clk);
    repeat (16) @(negedge clk);
    if (voice.pending() != 0) begin
      $error("%0d expected result items never arrived", voice.pending());
      voice.errors++;
    end
    if (voice.errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule
